>>> rtl/core/ps2mpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2mpt_pkg;

  // Width of one cursor coordinate.
  localparam int COORD_BITS = 12;

  // Field widths fixed by the interface.
  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 13;
  localparam int DELTA_W = 10;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  // Configuration reset values.
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  // Packet byte position codes.
  localparam logic [1:0] IDX_FLAGS = 2'd0;
  localparam logic [1:0] IDX_XMOVE = 2'd1;
  localparam logic [1:0] IDX_YMOVE = 2'd2;

  // Flags byte bit positions.
  localparam int FLAG_LEFT   = 0;
  localparam int FLAG_RIGHT  = 1;
  localparam int FLAG_MIDDLE = 2;
  localparam int FLAG_XSIGN  = 4;
  localparam int FLAG_YSIGN  = 5;
  localparam int FLAG_XOVF   = 6;
  localparam int FLAG_YOVF   = 7;

endpackage

`default_nettype wire

>>> rtl/core/ps2mpt_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mpt_axis (
  input  wire logic [ps2mpt_pkg::COORD_BITS-1:0]    pos_i,
  input  wire logic signed [ps2mpt_pkg::DELTA_W-1:0] delta_i,
  input  wire logic [ps2mpt_pkg::SIZE_W-1:0]        size_i,
  output logic [ps2mpt_pkg::COORD_BITS-1:0]         pos_o
);
  import ps2mpt_pkg::*;

  // The limit must hold both the screen size and the full coordinate span.
  localparam int LIM_W = (SIZE_W > COORD_BITS + 1) ? SIZE_W : COORD_BITS + 1;
  localparam int CMP_W = LIM_W + 1;
  localparam logic [LIM_W-1:0] SPAN = LIM_W'(1) << COORD_BITS;

  logic [LIM_W-1:0]        size_ext;
  logic [LIM_W-1:0]        lim;
  logic [LIM_W-1:0]        lim_m1;
  logic signed [CMP_W-1:0] sum;

  // Effective screen size: zero acts as one, oversize acts as the full span.
  always_comb begin
    size_ext = LIM_W'(size_i);
    if (size_ext == '0) begin
      lim = LIM_W'(1);
    end else if (size_ext > SPAN) begin
      lim = SPAN;
    end else begin
      lim = size_ext;
    end
    lim_m1 = lim - LIM_W'(1);
  end

  // Move and clamp to 0..lim-1.
  always_comb begin
    sum = $signed({{(CMP_W - COORD_BITS){1'b0}}, pos_i})
        + $signed({{(CMP_W - DELTA_W){delta_i[DELTA_W-1]}}, delta_i});
    if (sum[CMP_W-1]) begin
      pos_o = '0;
    end else if (sum > $signed({1'b0, lim_m1})) begin
      pos_o = lim_m1[COORD_BITS-1:0];
    end else begin
      pos_o = sum[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ps2mpt_top.sv
`timescale 1ns / 1ps
`default_nettype none

// PS/2 mouse packet tracker. Received mouse bytes are grouped into three-byte
// packets (flags, X movement, Y movement); each complete packet moves the
// cursor by X and by minus Y, clamps it to the configured screen, and yields
// one request carrying the position and the left, right and middle buttons.
// Packets with either overflow flag set are dropped with no request and no
// position change. The flags sync bit is not checked, so the first byte after
// reset is taken as a flags byte. One byte is accepted every clock cycle while
// the result side keeps up; a result request is formed from its third byte
// through the input register and then the result register. Screen width and
// height (register indexes 0 and 1, reset 1024 and 768) are to be written only
// while the block is idle; the block itself does not enforce this.
module ps2_mouse_packet_tracker_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [ps2mpt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ps2mpt_pkg::SIZE_W-1:0]        cfg_data_i,
  // Byte input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [ps2mpt_pkg::BYTE_W-1:0]        rx_byte_i,
  // Result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [ps2mpt_pkg::COORD_BITS-1:0]         cursor_x_o,
  output logic [ps2mpt_pkg::COORD_BITS-1:0]         cursor_y_o,
  output logic                                      left_button_o,
  output logic                                      right_button_o,
  output logic                                      middle_button_o
);
  import ps2mpt_pkg::*;

  logic [SIZE_W-1:0]     width_q, height_q;
  logic                  in_valid_q;
  logic [BYTE_W-1:0]     in_byte_q;
  logic [1:0]            idx_q, idx_d;
  logic [BYTE_W-1:0]     flags_q, flags_d;
  logic [BYTE_W-1:0]     xmove_q, xmove_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0] new_x, new_y;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic [2:0]            buttons_q;
  logic                  advance;
  logic                  emit;
  logic signed [DELTA_W-1:0] dx, dy_neg;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The work stage moves when the result register is free or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Sign-extended movements; Y is negated because screen Y grows downward.
  assign dx     = $signed({flags_q[FLAG_XSIGN], flags_q[FLAG_XSIGN], xmove_q});
  assign dy_neg = -$signed({flags_q[FLAG_YSIGN], flags_q[FLAG_YSIGN], in_byte_q});

  ps2mpt_axis u_axis_x (
    .pos_i   (pos_x_q),
    .delta_i (dx),
    .size_i  (width_q),
    .pos_o   (new_x)
  );

  ps2mpt_axis u_axis_y (
    .pos_i   (pos_y_q),
    .delta_i (dy_neg),
    .size_i  (height_q),
    .pos_o   (new_y)
  );

  // Packet assembly sequencer.
  always_comb begin
    idx_d   = idx_q;
    flags_d = flags_q;
    xmove_d = xmove_q;
    emit    = 1'b0;
    if (in_valid_q && advance) begin
      unique case (idx_q)
        IDX_XMOVE: begin
          xmove_d = in_byte_q;
          idx_d   = IDX_YMOVE;
        end
        IDX_YMOVE: begin
          idx_d = IDX_FLAGS;
          emit  = !(flags_q[FLAG_XOVF] || flags_q[FLAG_YOVF]);
        end
        default: begin
          flags_d = in_byte_q;
          idx_d   = IDX_XMOVE;
        end
      endcase
    end
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  // Packet and cursor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IDX_FLAGS;
      flags_q     <= '0;
      xmove_q     <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      flags_q     <= flags_d;
      xmove_q     <= xmove_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        pos_x_q <= new_x;
        pos_y_q <= new_y;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      cur_x_q   <= new_x;
      cur_y_q   <= new_y;
      buttons_q <= {flags_q[FLAG_MIDDLE], flags_q[FLAG_RIGHT], flags_q[FLAG_LEFT]};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_x_o      = cur_x_q;
  assign cursor_y_o      = cur_y_q;
  assign left_button_o   = buttons_q[0];
  assign right_button_o  = buttons_q[1];
  assign middle_button_o = buttons_q[2];

endmodule

`default_nettype wire

>>> test/ps2mpt_cursor_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, byte and result channels of the packet tracker.
// It predicts each cursor report from the accepted bytes and compares every
// accepted report with the oldest prediction.
module ps2mpt_cursor_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_i,
  input  wire logic [ps2mpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ps2mpt_pkg::SIZE_W-1:0]     cfg_data_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_i,
  input  wire logic [ps2mpt_pkg::BYTE_W-1:0]     rx_byte_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_stall_i,
  input  wire logic [ps2mpt_pkg::COORD_BITS-1:0] cursor_x_i,
  input  wire logic [ps2mpt_pkg::COORD_BITS-1:0] cursor_y_i,
  input  wire logic                              left_button_i,
  input  wire logic                              right_button_i,
  input  wire logic                              middle_button_i,
  output int                                     mismatches_o,
  output int                                     pending_o
);
  import ps2mpt_pkg::*;

  // A movement byte with its sign flag set counts this much less.
  localparam int SIGN_WEIGHT = 1 << BYTE_W;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  right;
    logic                  middle;
  } cursor_report_t;

  cursor_report_t expected_reports[$];

  // Predicted tracker state and screen size.
  logic [1:0]            pkt_pos;
  logic [BYTE_W-1:0]     held_flags;
  logic [BYTE_W-1:0]     held_dx;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [SIZE_W-1:0]     scr_width;
  logic [SIZE_W-1:0]     scr_height;

  // A size of zero behaves as one, and anything past the coordinate range
  // behaves as the full range.
  function automatic logic [COORD_BITS-1:0] clamp_to_screen(input int pos,
                                                            input logic [SIZE_W-1:0] size);
    int lim;
    lim = int'(size);
    if (lim < 1) lim = 1;
    if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
    if (pos < 0) return '0;
    if (pos > lim - 1) return COORD_BITS'(lim - 1);
    return COORD_BITS'(pos);
  endfunction

  // Advances the packet assembly by one byte and queues a report when a
  // packet without overflow completes.
  task automatic track_byte(input logic [BYTE_W-1:0] b);
    int dx;
    int dy;
    cursor_report_t rep;
    if (pkt_pos == IDX_XMOVE) begin
      held_dx = b;
      pkt_pos = IDX_YMOVE;
    end else if (pkt_pos != IDX_YMOVE) begin
      held_flags = b;
      pkt_pos = IDX_XMOVE;
    end else begin
      pkt_pos = IDX_FLAGS;
      if (!held_flags[FLAG_XOVF] && !held_flags[FLAG_YOVF]) begin
        dx = int'(held_dx);
        if (held_flags[FLAG_XSIGN]) dx -= SIGN_WEIGHT;
        dy = int'(b);
        if (held_flags[FLAG_YSIGN]) dy -= SIGN_WEIGHT;
        // Screen Y grows downward, so upward mouse motion lowers it.
        cur_x = clamp_to_screen(int'(cur_x) + dx, scr_width);
        cur_y = clamp_to_screen(int'(cur_y) - dy, scr_height);
        rep.x = cur_x;
        rep.y = cur_y;
        rep.left = held_flags[FLAG_LEFT];
        rep.right = held_flags[FLAG_RIGHT];
        rep.middle = held_flags[FLAG_MIDDLE];
        expected_reports.push_back(rep);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [COORD_BITS-1:0] want,
                             input logic [COORD_BITS-1:0] got);
    if (got !== want) begin
      mismatches_o++;
      if (mismatches_o <= MAX_REPORTED)
        $display("cursor report %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Results are compared before the same edge's byte is tracked; a byte can
  // never produce a report on the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t want;
    if (!rst_ni) begin
      pkt_pos = IDX_FLAGS;
      held_flags = '0;
      held_dx = '0;
      cur_x = '0;
      cur_y = '0;
      scr_width = SCREEN_WIDTH_RST;
      scr_height = SCREEN_HEIGHT_RST;
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SCREEN_WIDTH) scr_width = cfg_data_i;
        else if (cfg_index_i == CFG_SCREEN_HEIGHT) scr_height = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MAX_REPORTED)
            $display("unexpected cursor report x=%0d y=%0d", cursor_x_i, cursor_y_i);
        end else begin
          want = expected_reports.pop_front();
          check_field("cursor_x", want.x, cursor_x_i);
          check_field("cursor_y", want.y, cursor_y_i);
          check_field("left_button", COORD_BITS'(want.left), COORD_BITS'(left_button_i));
          check_field("right_button", COORD_BITS'(want.right),
                      COORD_BITS'(right_button_i));
          check_field("middle_button", COORD_BITS'(want.middle),
                      COORD_BITS'(middle_button_i));
        end
      end
      if (in_valid_i && !in_stall_i) track_byte(rx_byte_i);
      pending_o <= expected_reports.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// Drives mouse bytes and screen sizes into the packet tracker through several
// idle and stall phases; the checker beside the block predicts and compares.
module tb;
  import ps2mpt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PACKETS_PER_PHASE = 39;
  localparam int PHASES = 8;
  localparam int HOLD_PHASE = 4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [SIZE_W-1:0]     cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     rx_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COORD_BITS-1:0] cursor_x_o;
  logic [COORD_BITS-1:0] cursor_y_o;
  logic                  left_button_o;
  logic                  right_button_o;
  logic                  middle_button_o;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int report_mismatches;
  int reports_pending;

  // Directed packets: all-zero, full positive X with negative Y, all three
  // buttons and sync bit with X underflow, three overflow packets, both signs
  // at the far end, and a right click.
  logic [BYTE_W-1:0] directed_bytes [24] = '{
    8'h00, 8'h00, 8'h00,
    8'h27, 8'hFF, 8'h80,
    8'h1F, 8'h00, 8'hFF,
    8'h40, 8'h55, 8'h55,
    8'h80, 8'hAA, 8'hAA,
    8'hF8, 8'h7F, 8'h01,
    8'h38, 8'h01, 8'h01,
    8'h02, 8'hFF, 8'h00
  };

  // Screen sizes per phase, including zero, oversized and both range ends.
  // The last phase picks its own.
  int phase_width  [PHASES] = '{0, 8191, 4096, 1, 4096, 37, 640, 0};
  int phase_height [PHASES] = '{0, 8191, 4096, 4096, 1, 5, 480, 0};
  // Preferred direction of motion per phase, so that the far edges get hit.
  bit drift_right  [PHASES] = '{1, 1, 1, 0, 1, 0, 1, 0};
  bit drift_down   [PHASES] = '{1, 1, 1, 1, 0, 1, 0, 1};

  ps2_mouse_packet_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_o      (cursor_x_o),
    .cursor_y_o      (cursor_y_o),
    .left_button_o   (left_button_o),
    .right_button_o  (right_button_o),
    .middle_button_o (middle_button_o)
  );

  ps2mpt_cursor_checker cursor_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_x_i      (cursor_x_o),
    .cursor_y_i      (cursor_y_o),
    .left_button_i   (left_button_o),
    .right_button_i  (right_button_o),
    .middle_button_i (middle_button_o),
    .mismatches_o    (report_mismatches),
    .pending_o       (reports_pending)
  );

  always #6 clk_i = ~clk_i;

  // Result side: random stalls, or a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ps2_mouse_packet_tracker_top: mismatch");
      $finish;
    end
  end

  // Offers one byte, holds it until taken, then maybe idles for a while.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Mostly well-formed packets with random content biased toward one corner;
  // the rest are overflow packets and stray bytes that shift the framing.
  task automatic send_random_packet(input bit right, input bit down);
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy;
    int kind;
    kind = $urandom_range(99);
    flags = BYTE_W'($urandom);
    dx = BYTE_W'($urandom);
    dy = BYTE_W'($urandom);
    if (kind < 4) begin
      send_byte(flags);
      return;
    end
    if (kind < 12) begin
      flags[FLAG_XOVF + $urandom_range(1)] = 1'b1;
    end else begin
      flags[FLAG_XOVF] = 1'b0;
      flags[FLAG_YOVF] = 1'b0;
      if (kind < 75) begin
        flags[FLAG_XSIGN] = !right;
        flags[FLAG_YSIGN] = down;
      end
    end
    send_byte(flags);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Stops sending and waits for every predicted report, plus a few cycles
  // for a trailing overflow packet that produces none.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reports_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes width then height with one continuous valid.
  task automatic set_screen_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SCREEN_WIDTH;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_SCREEN_HEIGHT;
    cfg_data_i <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets at the reset screen size.
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 58;
        end
        default: begin
          send_idle_pct = 12;
          stall_pct = 12;
        end
      endcase
      if (p == PHASES - 1) begin
        phase_width[p] = $urandom_range(1, 4096);
        phase_height[p] = $urandom_range(1, 4096);
      end
      set_screen_size(SIZE_W'(phase_width[p]), SIZE_W'(phase_height[p]));
      // Back up the block while bytes keep coming.
      if (p == HOLD_PHASE) hold_requests++;
      repeat (PACKETS_PER_PHASE) send_random_packet(drift_right[p], drift_down[p]);
    end
    wait_for_drain();

    if (report_mismatches == 0 && reports_pending == 0)
      $display("ps2_mouse_packet_tracker_top: match");
    else
      $display("ps2_mouse_packet_tracker_top: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/core/ps2mpt_pkg.sv
rtl/core/ps2mpt_axis.sv
rtl/core/ps2mpt_top.sv
test/ps2mpt_cursor_checker.sv
test/tb.sv
